@@ design/i2a_pkg.sv @@
package i2a_pkg;

	// Format commands carried in the cmd field.
	typedef enum logic [1:0] {
		CMD_SDEC = 2'd0,
		CMD_UDEC = 2'd1,
		CMD_HEXL = 2'd2,
		CMD_HEXU = 2'd3
	} cmd_t;

	// Input and result payloads.
	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] value;
		logic        clear_count;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_char;
		logic        last_char;
		logic [30:0] char_count;
	} out_item_t;

	localparam int unsigned DIGIT_SLOTS = 16;
	localparam int unsigned SLOT_W = $clog2(DIGIT_SLOTS);
	localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;
	// floor(v / 10) == (v * RECIP10) >> 35 for every 32-bit v.
	localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
	localparam int unsigned RECIP_SHIFT = 35;

	// Datapath operations selected by the control word.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_MUL,
		OP_DDIG,
		OP_HDIG,
		OP_SIGN,
		OP_EMIT
	} op_t;

	// Jump conditions; when the condition holds the sequencer goes to the target,
	// otherwise it steps to the next address.
	typedef enum logic [2:0] {
		JC_NEVER,
		JC_ALWAYS,
		JC_NO_INPUT,
		JC_HEX,
		JC_MORE,
		JC_SIGN_WAIT,
		JC_EMIT_WAIT
	} jc_t;

	localparam int unsigned UPC_W = 3;
	typedef logic [UPC_W-1:0] upc_t;

	// Program addresses.
	localparam upc_t ST_LOAD     = 3'd0;
	localparam upc_t ST_DISPATCH = 3'd1;
	localparam upc_t ST_MUL      = 3'd2;
	localparam upc_t ST_DDIG     = 3'd3;
	localparam upc_t ST_JOIN     = 3'd4;
	localparam upc_t ST_HDIG     = 3'd5;
	localparam upc_t ST_SIGN     = 3'd6;
	localparam upc_t ST_EMIT     = 3'd7;

	typedef struct packed {
		op_t  op;
		jc_t  cond;
		upc_t target;
	} uword_t;

	// Status flags from the datapath that the jump conditions test.
	typedef struct packed {
		logic hex;
		logic more;
		logic sign_wait;
		logic emit_wait;
	} stat_t;

	// Control store. The last step falls through to address zero.
	function automatic uword_t ucode(input upc_t addr);
		uword_t w;
		unique case (addr)
			ST_LOAD:     w = '{op: OP_LOAD, cond: JC_NO_INPUT,  target: ST_LOAD};
			ST_DISPATCH: w = '{op: OP_NOP,  cond: JC_HEX,       target: ST_HDIG};
			ST_MUL:      w = '{op: OP_MUL,  cond: JC_NEVER,     target: ST_MUL};
			ST_DDIG:     w = '{op: OP_DDIG, cond: JC_MORE,      target: ST_MUL};
			ST_JOIN:     w = '{op: OP_NOP,  cond: JC_ALWAYS,    target: ST_SIGN};
			ST_HDIG:     w = '{op: OP_HDIG, cond: JC_MORE,      target: ST_HDIG};
			ST_SIGN:     w = '{op: OP_SIGN, cond: JC_SIGN_WAIT, target: ST_SIGN};
			ST_EMIT:     w = '{op: OP_EMIT, cond: JC_EMIT_WAIT, target: ST_EMIT};
			default:     w = '{op: OP_NOP,  cond: JC_ALWAYS,    target: ST_LOAD};
		endcase
		return w;
	endfunction

	// ASCII for one digit value in the chosen letter case.
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = 8'h30 + {4'h0, d};
		end else if (upper) begin
			c = 8'h41 + {4'h0, d - 4'd10};
		end else begin
			c = 8'h61 + {4'h0, d - 4'd10};
		end
		return c;
	endfunction

endpackage

@@ design/i2a_seq.sv @@
module i2a_seq
	import i2a_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  stat_t stat,
	output op_t   op
);

	upc_t   upc_q;
	uword_t uw;
	logic   take;

	assign uw = ucode(upc_q);
	assign op = uw.op;

	// Evaluate the jump condition of the current control word.
	always_comb begin
		unique case (uw.cond)
			JC_NEVER:     take = 1'b0;
			JC_ALWAYS:    take = 1'b1;
			JC_NO_INPUT:  take = !in_valid;
			JC_HEX:       take = stat.hex;
			JC_MORE:      take = stat.more;
			JC_SIGN_WAIT: take = stat.sign_wait;
			JC_EMIT_WAIT: take = stat.emit_wait;
			default:      take = 1'b0;
		endcase
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ST_LOAD;
		end else begin
			upc_q <= take ? uw.target : upc_t'(upc_q + upc_t'(1));
		end
	end

endmodule

@@ design/i2a_dp.sv @@
module i2a_dp
	import i2a_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  op_t       op,
	input  logic      in_valid,
	input  in_item_t  in_item,
	input  logic      out_ready,
	output logic      out_valid,
	output out_item_t out_item,
	output stat_t     stat
);

	logic [63:0]        mag_q;
	logic [28:0]        quot_q;
	logic [3:0]         buf_q [DIGIT_SLOTS];
	logic [SLOT_W:0]    dcnt_q;
	logic               sign_q;
	logic               hex_q;
	logic               upper_q;
	logic [30:0]        run_q;
	logic               out_valid_q;
	out_item_t          out_item_q;

	logic               accept;
	logic               busy;
	logic [63:0]        product;
	logic [3:0]         q10_low;
	logic [3:0]         dec_digit;
	logic [SLOT_W-1:0]  wr_idx;
	logic [SLOT_W-1:0]  rd_idx;
	logic               room;
	logic               do_sign;
	logic               do_emit;
	logic [30:0]        run_base;
	logic [30:0]        run_next;
	logic [31:0]        low_word;
	logic               neg;
	logic [63:0]        load_mag;

	assign accept = (op == OP_LOAD) && in_valid;
	assign busy   = out_valid_q && !out_ready;

	// Decimal step: quotient from the registered reciprocal product, and the
	// remainder from the low bits only, since it is below ten.
	assign product   = 64'(mag_q[31:0]) * 64'(RECIP10);
	assign q10_low   = 4'({quot_q[0], 3'b000} + {quot_q[2:0], 1'b0});
	assign dec_digit = mag_q[3:0] - q10_low;

	assign wr_idx = dcnt_q[SLOT_W-1:0];
	assign rd_idx = SLOT_W'(dcnt_q - (SLOT_W+1)'(1));
	assign room   = dcnt_q < (SLOT_W+1)'(DIGIT_SLOTS - 1);

	assign do_sign = (op == OP_SIGN) && sign_q && !busy;
	assign do_emit = (op == OP_EMIT) && !busy;

	// Running count, saturating.
	assign run_base = run_q;
	assign run_next = (run_base != COUNT_MAX) ? 31'(run_base + 31'd1) : run_base;

	// Magnitude selection at load.
	assign low_word = in_item.value[31:0];
	assign neg      = (in_item.cmd == CMD_SDEC) && low_word[31];
	always_comb begin
		if (neg) begin
			load_mag = {32'h0, 32'(~low_word + 32'd1)};
		end else if (in_item.cmd == CMD_SDEC || in_item.cmd == CMD_UDEC) begin
			load_mag = {32'h0, low_word};
		end else begin
			load_mag = in_item.value;
		end
	end

	// Status for the sequencer.
	always_comb begin
		stat.hex       = hex_q;
		stat.more      = room && ((op == OP_DDIG) ? (quot_q != 29'd0) : (mag_q[63:4] != 60'd0));
		stat.sign_wait = sign_q && busy;
		stat.emit_wait = busy || (dcnt_q > (SLOT_W+1)'(1));
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q      <= '0;
			sign_q      <= 1'b0;
			hex_q       <= 1'b0;
			run_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				dcnt_q <= '0;
				sign_q <= neg;
				hex_q  <= (in_item.cmd == CMD_HEXL) || (in_item.cmd == CMD_HEXU);
				if (in_item.clear_count) begin
					run_q <= '0;
				end
			end
			if (op == OP_DDIG || op == OP_HDIG) begin
				dcnt_q <= dcnt_q + (SLOT_W+1)'(1);
			end
			if (do_sign) begin
				sign_q <= 1'b0;
			end
			if (do_emit) begin
				dcnt_q <= dcnt_q - (SLOT_W+1)'(1);
			end
			if (do_sign || do_emit) begin
				run_q       <= run_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers and the digit buffer.
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q   <= load_mag;
			upper_q <= in_item.cmd == CMD_HEXU;
		end
		if (op == OP_MUL) begin
			quot_q <= product[63:RECIP_SHIFT];
		end
		if (op == OP_DDIG) begin
			buf_q[wr_idx] <= dec_digit;
			mag_q         <= {35'h0, quot_q};
		end
		if (op == OP_HDIG) begin
			buf_q[wr_idx] <= mag_q[3:0];
			mag_q         <= {4'h0, mag_q[63:4]};
		end
		if (do_sign) begin
			out_item_q.out_char   <= 8'h2D;
			out_item_q.last_char  <= 1'b0;
			out_item_q.char_count <= run_next;
		end
		if (do_emit) begin
			out_item_q.out_char   <= digit_char(buf_q[rd_idx], upper_q);
			out_item_q.last_char  <= dcnt_q == (SLOT_W+1)'(1);
			out_item_q.char_count <= run_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

@@ design/integer_to_ascii_formatter.sv @@
// Integer to ASCII formatter. Each accepted item is turned into 1 to 16 ASCII
// characters (optional '-', then digits, most significant first, no leading
// zeros), one result transfer per character, with last_char on the final one
// and a saturating running character count. A small microcoded sequencer
// drives the datapath. Decimal conversion makes each digit by a 32x32
// reciprocal multiply by 1/10, then the quotient and remainder step; hex
// conversion takes each digit straight from the low four bits; characters
// then leave at one per cycle while the output is not stalled. A new item is
// taken once the last character of the previous one has been loaded into
// the output register, even if that character still waits.
module integer_to_ascii_formatter
	import i2a_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	op_t   op;
	stat_t stat;

	// Items are taken only at the load step of the program.
	assign in_ready = op == OP_LOAD;

	i2a_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.op       (op)
	);

	i2a_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.in_valid  (in_valid),
		.in_item   (in_item),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_item  (out_item),
		.stat      (stat)
	);

endmodule
